/* rtl/core/gsa_pkg.sv */
// Shared types, widths and codes for the generational slot allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package gsa_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int GEN_W     = 16;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = SLOT_W + 1;

   // Fixed field widths of the channels
   localparam int CAP_W      = 11;
   localparam int KIND_W     = 2;
   localparam int HIDX_W     = 12;
   localparam int STATUS_W   = 2;
   localparam int OUT_IDX_W  = 10;
   localparam int FREED_W    = 11;
   localparam int CAP_RESET  = 1024;

   typedef enum logic [KIND_W-1:0] {
      REQ_ALLOC    = 2'd0,
      REQ_DESTROY  = 2'd1,
      REQ_VALIDATE = 2'd2,
      REQ_COMMIT   = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic accept;     // latch request fields
      logic pop;        // pop free stack top
      logic slot_rd;    // read generation of popped slot
      logic handle_rd;  // read generation of handle slot
      logic walk;       // commit: move one pending entry
      logic emit;       // load result register, apply destroy/commit updates
      logic clear;      // clear one generation entry
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic walk_done;
      logic clear_last;
   } dp_stat_type;

   function automatic logic [CNT_W-1:0] clamp_cap(input logic [31:0] v);
      logic [CNT_W-1:0] r;
      if (v == 32'd0)
         r = CNT_W'(1);
      else if (v > 32'(MAX_SLOTS))
         r = CNT_W'(MAX_SLOTS);
      else
         r = CNT_W'(v);
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/gsa_if.sv */
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on gsa_pkg for field widths.
`default_nettype none

interface gsa_req_if import gsa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [HIDX_W-1:0]   handle_index;
   logic [GEN_W-1:0]    handle_generation;

   modport source (output valid, req_type, handle_index, handle_generation, input ready);
   modport sink   (input valid, req_type, handle_index, handle_generation, output ready);
endinterface

interface gsa_rsp_if import gsa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [OUT_IDX_W-1:0] slot_index;
   logic [GEN_W-1:0]     slot_generation;
   logic                 handle_valid;
   logic [FREED_W-1:0]   freed_count;

   modport source (output valid, status, slot_index, slot_generation, handle_valid,
                   freed_count, input ready);
   modport sink   (input valid, status, slot_index, slot_generation, handle_valid,
                   freed_count, output ready);
endinterface

interface gsa_csr_if import gsa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] slot_capacity;

   modport source (output valid, slot_capacity, input ready);
   modport sink   (input valid, slot_capacity, output ready);
endinterface

`default_nettype wire

/* rtl/core/gsa_ctrl.sv */
// Sequencing state machine for the slot allocator.
// Depends on gsa_pkg; drives gsa_dp through dp_cmd_type, watches dp_stat_type.
`default_nettype none

module gsa_ctrl import gsa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic              req_valid,
   input  wire logic [KIND_W-1:0] req_kind,
   output logic                   req_ready,
   input  wire dp_stat_type       stat,
   output dp_cmd_type             cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_POP,
      S_ALLOC_GEN,
      S_HANDLE_RD,
      S_COMMIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_kind_type'(req_kind))
                  REQ_ALLOC:                 state_in = S_POP;
                  REQ_DESTROY, REQ_VALIDATE: state_in = S_HANDLE_RD;
                  REQ_COMMIT:                state_in = S_COMMIT;
                  default:                   state_in = S_IDLE;
               endcase
            end
         end
         S_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_ALLOC_GEN;
         end
         S_ALLOC_GEN: begin
            cmd.slot_rd = 1'b1;
            state_in    = S_DONE;
         end
         S_HANDLE_RD: begin
            cmd.handle_rd = 1'b1;
            state_in      = S_DONE;
         end
         S_COMMIT: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // a capacity write restarts the generation clearing pass
      if (csr_write) begin
         cmd       = '0;
         req_ready = 1'b0;
         state_in  = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

/* rtl/core/gsa_dp.sv */
// Datapath: free stack, generation table and pending list memories,
// counters and the response register. Depends on gsa_pkg.
`default_nettype none

module gsa_dp import gsa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dp_cmd_type           cmd,
   output dp_stat_type               stat,
   input  wire logic                 csr_write,
   input  wire logic [CAP_W-1:0]     csr_cap,
   input  wire logic [KIND_W-1:0]    req_kind,
   input  wire logic [HIDX_W-1:0]    req_hidx,
   input  wire logic [GEN_W-1:0]     req_hgen,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [OUT_IDX_W-1:0]      rsp_slot_index,
   output logic [GEN_W-1:0]          rsp_slot_generation,
   output logic                      rsp_handle_valid,
   output logic [FREED_W-1:0]        rsp_freed_count
);

   // memories
   logic [SLOT_W-1:0] stack_mem_ff [MAX_SLOTS];
   logic [GEN_W-1:0]  gen_mem_ff   [MAX_SLOTS];
   logic [SLOT_W-1:0] pend_mem_ff  [MAX_SLOTS];

   // control state
   logic [CNT_W-1:0]  cap_ff, fc_ff, pc_ff, prist_ff, walk_ff, freed_ff, clr_ff;
   logic              rd_pend_ff, rsp_valid_ff;

   // request and intermediate payload
   req_kind_type      kind_ff;
   logic [SLOT_W-1:0] hidx_ff, slot_ff, pval_ff;
   logic [GEN_W-1:0]  hgen_ff;
   logic              in_range_ff, fail_ff, pristine_ff;
   logic [SLOT_W-1:0] stk_rd_ff, pend_rd_ff;
   logic [GEN_W-1:0]  gen_rd_ff;

   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [OUT_IDX_W-1:0] out_idx_ff, out_idx_in;
   logic [GEN_W-1:0]     out_gen_ff, out_gen_in;
   logic                 out_hv_ff, out_hv_in;
   logic [FREED_W-1:0]   out_freed_ff, out_freed_in;

   // memory port controls
   logic              stk_we, stk_re, gen_we, gen_re, pend_we, pend_re;
   logic [SLOT_W-1:0] stk_waddr, stk_raddr, gen_waddr, gen_raddr, pend_waddr, pend_raddr;
   logic [SLOT_W-1:0] stk_wdata, pend_wdata;
   logic [GEN_W-1:0]  gen_wdata;

   logic [CNT_W-1:0]  fc_dec, cap_new;
   logic              handle_ok, push_ok, walk_more;
   logic [SLOT_W-1:0] slot_sel;

   assign fc_dec    = fc_ff - CNT_W'(1);
   assign cap_new   = clamp_cap(32'(csr_cap));
   assign handle_ok = in_range_ff && (gen_rd_ff == hgen_ff);
   assign push_ok   = rd_pend_ff && (fc_ff < cap_ff);
   assign walk_more = (walk_ff != pc_ff);
   // stack entries below the watermark were never written since reinit
   assign slot_sel  = pristine_ff ? pval_ff : stk_rd_ff;

   assign stat.out_free   = !rsp_valid_ff || rsp_ready;
   assign stat.walk_done  = !walk_more && !rd_pend_ff;
   assign stat.clear_last = (clr_ff == CNT_W'(MAX_SLOTS - 1));

   always_comb begin
      stk_we     = cmd.walk && push_ok;
      stk_waddr  = fc_ff[SLOT_W-1:0];
      stk_wdata  = pend_rd_ff;
      stk_re     = cmd.pop && (fc_ff != '0);
      stk_raddr  = fc_dec[SLOT_W-1:0];

      pend_we    = cmd.emit && (kind_ff == REQ_DESTROY) && handle_ok && (pc_ff < cap_ff);
      pend_waddr = pc_ff[SLOT_W-1:0];
      pend_wdata = hidx_ff;
      pend_re    = cmd.walk && walk_more;
      pend_raddr = walk_ff[SLOT_W-1:0];

      gen_we     = cmd.clear || pend_we;
      gen_waddr  = cmd.clear ? clr_ff[SLOT_W-1:0] : hidx_ff;
      gen_wdata  = cmd.clear ? '0 : gen_rd_ff + GEN_W'(1);
      gen_re     = cmd.slot_rd || cmd.handle_rd;
      gen_raddr  = cmd.slot_rd ? slot_sel : hidx_ff;
   end

   // response payload for the request in work
   always_comb begin
      status_in    = ST_OK;
      out_idx_in   = '0;
      out_gen_in   = '0;
      out_hv_in    = 1'b0;
      out_freed_in = '0;
      case (kind_ff)
         REQ_ALLOC: begin
            if (fail_ff) begin
               status_in = ST_FULL;
            end else begin
               out_idx_in = OUT_IDX_W'(slot_ff);
               out_gen_in = gen_rd_ff;
            end
         end
         REQ_DESTROY: begin
            if (!handle_ok) begin
               status_in = ST_INVALID;
            end else begin
               out_hv_in = 1'b1;
               if (pc_ff >= cap_ff) status_in = ST_FULL;
            end
         end
         REQ_VALIDATE: begin
            if (handle_ok) out_hv_in = 1'b1;
            else           status_in = ST_INVALID;
         end
         REQ_COMMIT: out_freed_in = FREED_W'(freed_ff);
         default: status_in = ST_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem_ff[stk_waddr] <= stk_wdata;
      if (stk_re) stk_rd_ff <= stack_mem_ff[stk_raddr];
   end

   always_ff @(posedge clock) begin
      if (gen_we) gen_mem_ff[gen_waddr] <= gen_wdata;
      if (gen_re) gen_rd_ff <= gen_mem_ff[gen_raddr];
   end

   always_ff @(posedge clock) begin
      if (pend_we) pend_mem_ff[pend_waddr] <= pend_wdata;
      if (pend_re) pend_rd_ff <= pend_mem_ff[pend_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff     <= req_kind_type'(req_kind);
         hidx_ff     <= req_hidx[SLOT_W-1:0];
         hgen_ff     <= req_hgen;
         in_range_ff <= (32'(req_hidx) < 32'(cap_ff));
      end
      if (cmd.pop) begin
         fail_ff     <= (fc_ff == '0);
         pristine_ff <= (fc_ff <= prist_ff);
         pval_ff     <= SLOT_W'(cap_ff - fc_ff);
      end
      if (cmd.slot_rd) slot_ff <= slot_sel;
      if (cmd.emit) begin
         status_ff    <= status_in;
         out_idx_ff   <= out_idx_in;
         out_gen_ff   <= out_gen_in;
         out_hv_ff    <= out_hv_in;
         out_freed_ff <= out_freed_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= clamp_cap(32'(CAP_RESET));
         fc_ff        <= clamp_cap(32'(CAP_RESET));
         prist_ff     <= clamp_cap(32'(CAP_RESET));
         pc_ff        <= '0;
         walk_ff      <= '0;
         freed_ff     <= '0;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit)          rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;

         if (csr_write) begin
            cap_ff   <= cap_new;
            fc_ff    <= cap_new;
            prist_ff <= cap_new;
            pc_ff    <= '0;
            clr_ff   <= '0;
         end else begin
            if (cmd.clear) clr_ff <= clr_ff + CNT_W'(1);
            if (cmd.accept) begin
               walk_ff    <= '0;
               freed_ff   <= '0;
               rd_pend_ff <= 1'b0;
            end
            if (stk_re) fc_ff <= fc_dec;
            if (cmd.walk) begin
               rd_pend_ff <= walk_more;
               if (walk_more) walk_ff <= walk_ff + CNT_W'(1);
               if (push_ok) begin
                  fc_ff    <= fc_ff + CNT_W'(1);
                  freed_ff <= freed_ff + CNT_W'(1);
                  if (fc_ff < prist_ff) prist_ff <= fc_ff;
               end
            end
            if (pend_we) pc_ff <= pc_ff + CNT_W'(1);
            if (cmd.emit && (kind_ff == REQ_COMMIT)) pc_ff <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_slot_index      = out_idx_ff;
   assign rsp_slot_generation = out_gen_ff;
   assign rsp_handle_valid    = out_hv_ff;
   assign rsp_freed_count     = out_freed_ff;

endmodule

`default_nettype wire

/* rtl/core/generational_slot_allocator.sv */
// Top level of the generational slot allocator: controller plus datapath.
// Depends on gsa_pkg, gsa_if, gsa_ctrl and gsa_dp.
`default_nettype none

// Hands out slot handles (index, generation) from a LIFO free stack and
// checks them against a per-slot generation table; destroyed slots wait on
// a pending list until a commit request returns them to the stack. One
// request is in work at a time, with a registered response that may wait
// for rsp_ch.ready while the next request is taken. Allocate takes a slot
// from the free stack and then reads its generation; destroy and validate
// read the generation table once, destroy then writing the incremented
// generation back; commit walks the pending list one entry a cycle.
// After reset and after each capacity write the generation table is
// cleared, one entry a cycle, and no request is accepted until it is
// done; capacity writes are accepted at any time.
module generational_slot_allocator import gsa_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   gsa_req_if.sink    req_ch,
   gsa_rsp_if.source  rsp_ch,
   gsa_csr_if.sink    csr_ch
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   gsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gsa_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_write           (csr_write),
      .csr_cap             (csr_ch.slot_capacity),
      .req_kind            (req_ch.req_type),
      .req_hidx            (req_ch.handle_index),
      .req_hgen            (req_ch.handle_generation),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_slot_index      (rsp_ch.slot_index),
      .rsp_slot_generation (rsp_ch.slot_generation),
      .rsp_handle_valid    (rsp_ch.handle_valid),
      .rsp_freed_count     (rsp_ch.freed_count)
   );

endmodule

`default_nettype wire
